@@ sv/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SIZE       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_EMPTY      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd6;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] entry_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        ptr_dec = (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    // The word is sign-extended to 64 bits first so any entry width up to 64 bits works.
    function automatic entry_t to_entry(input logic [VALUE_W-1:0] v);
        logic [63:0] ext;
        ext      = 64'(signed'(v));
        to_entry = ext[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] from_entry(input entry_t e);
        logic [63:0] ext;
        ext        = 64'(signed'(e));
        from_entry = ext[VALUE_W-1:0];
    endfunction

endpackage

@@ sv/deq_ram.sv @@
`timescale 1ns / 1ps

module deq_ram #(
    parameter int RAM_DEPTH = 1024,
    parameter int RAM_WIDTH = 32,
    parameter int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [RAM_WIDTH-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [RAM_WIDTH-1:0] rd_data
);

    logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/double_ended_queue.sv @@
`timescale 1ns / 1ps

// Double-ended queue of DEPTH words in one synchronous RAM. A command is taken
// in every cycle (busy stays low), and its result, if any, appears on the
// result ports with done high in the cycle after the command was taken:
// the RAM port that serves pops and peeks registers its read in the same way.
// Results come out in command order, one per cycle at most, and must be
// captured in the cycle done is high. A push that fits gives no result; a push
// into a full queue gives a full status and drops the word. No clearing pass
// is needed after reset.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   command,
    input  logic [VALUE_W-1:0] push_value,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [VALUE_W-1:0] data_value,
    output logic [COUNT_W-1:0] entry_count,
    output logic               is_empty
);

    ptr_t front_reg, front_next;
    ptr_t back_reg, back_next;
    cnt_t count_reg, count_next;

    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;
    cnt_t              rcount_reg;
    logic              rd_sel_reg, rd_sel_next;

    logic   accept;
    logic   is_full;
    logic   is_none;
    logic   wr_en;
    ptr_t   wr_addr;
    logic   rd_en;
    ptr_t   rd_addr;
    entry_t rd_data;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign is_full = (count_reg == CNT_FULL);
    assign is_none = (count_reg == '0);

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        rd_sel_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = back_reg;
        rd_en       = 1'b0;
        rd_addr     = front_reg;

        if (accept)
        begin
            done_next = 1'b1;
            case (command)
                CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        front_next = ptr_dec(front_reg);
                        wr_en      = 1'b1;
                        wr_addr    = ptr_dec(front_reg);
                        count_next = count_reg + 1'b1;
                        done_next  = 1'b0;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        back_next  = ptr_inc(back_reg);
                        wr_en      = 1'b1;
                        wr_addr    = back_reg;
                        count_next = count_reg + 1'b1;
                        done_next  = 1'b0;
                    end
                end
                CMD_POP_FRONT, CMD_PEEK_FRONT:
                begin
                    if (is_none)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = front_reg;
                        rd_sel_next = 1'b1;
                        if (command == CMD_POP_FRONT)
                        begin
                            front_next = ptr_inc(front_reg);
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                CMD_POP_BACK, CMD_PEEK_BACK:
                begin
                    if (is_none)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = ptr_dec(back_reg);
                        rd_sel_next = 1'b1;
                        if (command == CMD_POP_BACK)
                        begin
                            back_next  = ptr_dec(back_reg);
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    // Size and empty queries only report the count.
                end
            endcase
        end
    end

    // A word written at one edge is readable at the next, and one command per
    // cycle never reads and writes in the same cycle.
    deq_ram #(
        .RAM_DEPTH (DEPTH),
        .RAM_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (to_entry(push_value)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            rd_sel_reg <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            rd_sel_reg <= rd_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rcount_reg <= count_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign data_value  = rd_sel_reg ? from_entry(rd_data) : '0;
    assign entry_count = COUNT_W'(rcount_reg);
    assign is_empty    = (rcount_reg == '0);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above queue depth");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (front_reg == back_reg) == (count_reg == '0 || count_reg == CNT_FULL))
        else $error("pointers disagree with entry count");

    a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_full
            && (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK))
        |=> !done)
        else $error("result given for a push that fit");

    a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command != CMD_PUSH_FRONT && command != CMD_PUSH_BACK)
        |=> done)
        else $error("missing result for a query");

    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rd_sel_reg |-> (done && status == ST_OK))
        else $error("memory word routed out without an ok result");

endmodule
